// ----- src/rdsc_pkg.sv -----
// rdsc_pkg: shared constants and types for the radix digit string converter
// no dependencies; imported by the divider and the top level, referenced by the interfaces
`timescale 1ns / 1ps

package rdsc_pkg;

   // table and value sizing
   localparam int ALPHABET_DEPTH = 62;
   localparam int VALUE_BITS     = 64;

   // fixed field widths of the channels
   localparam int CMD_W         = 1;
   localparam int IDX_FIELD_W   = 6;
   localparam int CHAR_W        = 8;
   localparam int VALUE_FIELD_W = 64;

   // derived widths
   localparam int AIDX_W  = $clog2(ALPHABET_DEPTH);
   localparam int RADIX_W = $clog2(ALPHABET_DEPTH + 1);
   localparam int DPTR_W  = $clog2(VALUE_BITS);
   localparam int DCNT_W  = $clog2(VALUE_BITS + 1);

   // divider: quotient bits resolved per cycle
   localparam int DIV_STEPS  = 8;
   localparam int DIV_CYCLES = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
   localparam int DIV_W      = DIV_CYCLES * DIV_STEPS;
   localparam int DCYC_W     = $clog2(DIV_CYCLES + 1);

   // request commands
   localparam logic [CMD_W-1:0] CMD_WRITE   = 1'b0;
   localparam logic [CMD_W-1:0] CMD_CONVERT = 1'b1;

   // divider status toward the sequencer
   typedef struct packed {
      logic done;
      logic quot_zero;
   } div_status_type;

endpackage

// ----- src/rdsc_req_if.sv -----
// rdsc_req_if: request channel (valid, ready, command and payload fields)
// depends on rdsc_pkg for field widths
`timescale 1ns / 1ps

interface rdsc_req_if;
   logic                                valid;
   logic                                ready;
   logic [rdsc_pkg::CMD_W-1:0]          cmd;
   logic [rdsc_pkg::IDX_FIELD_W-1:0]    index;
   logic [rdsc_pkg::CHAR_W-1:0]         char_code;
   logic [rdsc_pkg::VALUE_FIELD_W-1:0]  value;

   modport source (output valid, output cmd, output index, output char_code,
                   output value, input ready);
   modport sink   (input valid, input cmd, input index, input char_code,
                   input value, output ready);
endinterface

// ----- src/rdsc_rsp_if.sv -----
// rdsc_rsp_if: response channel (valid, ready, one output character per handshake)
// depends on rdsc_pkg for field widths
`timescale 1ns / 1ps

interface rdsc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rdsc_pkg::CHAR_W-1:0] digit_char;
   logic                        last;
   logic                        bad_alphabet;

   modport source (output valid, output digit_char, output last,
                   output bad_alphabet, input ready);
   modport sink   (input valid, input digit_char, input last,
                   input bad_alphabet, output ready);
endinterface

// ----- src/radix_digit_string_converter_unit.sv -----
// radix_digit_string_converter_unit: top level, sequencer, alphabet table and digit buffer
// depends on rdsc_pkg, rdsc_req_if, rdsc_rsp_if, rdsc_ram and rdsc_divider
//
// Usage:
//   req_chan carries one request per valid/ready handshake. A write request
//   (cmd 0) stores char_code at alphabet position index and gives no response;
//   positions at or beyond the table depth are ignored. A convert request
//   (cmd 1) turns value into characters of the base given by the alphabet.
//   rsp_chan returns one character per handshake, most significant first, with
//   last set on the final one. An invalid alphabet gives one response with
//   digit_char 0, last 1 and bad_alphabet 1.
// Timing:
//   a write request completes on its handshake. A convert request first walks
//   the alphabet one entry per cycle, then runs the shared divider once per
//   digit, then reads back and sends each character in turn, waiting for the
//   receiver on each one. req_chan.ready is high only while the block is idle;
//   one request at a time.
// Reset: synchronous; clears the alphabet to empty and drops any response.
// Stalls: a response is held on rsp_chan until taken; the block waits.
`timescale 1ns / 1ps

module radix_digit_string_converter_unit (
   input logic        clock,
   input logic        reset,
   rdsc_req_if.sink   req_chan,
   rdsc_rsp_if.source rsp_chan
);
   import rdsc_pkg::*;

   // character classes
   localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
   localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
   localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7a;
   localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5a;
   localparam int                ALNUM_N  = 62;
   localparam int                CODE_W   = $clog2(ALNUM_N);

   // sequencer states
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_CHK      = 3'd1;
   localparam logic [2:0] S_DIV      = 3'd2;
   localparam logic [2:0] S_LOOK     = 3'd3;
   localparam logic [2:0] S_OUT_RD   = 3'd4;
   localparam logic [2:0] S_OUT_LD   = 3'd5;
   localparam logic [2:0] S_OUT_WAIT = 3'd6;

   function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
      return (c >= CH_0 && c <= CH_9) || (c >= CH_LO_A && c <= CH_LO_Z) ||
             (c >= CH_UP_A && c <= CH_UP_Z);
   endfunction

   // dense code 0..61 for an alphanumeric character
   function automatic logic [CODE_W-1:0] alnum_code(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] off;
      off = '0;
      if (c >= CH_0 && c <= CH_9) begin
         off = c - CH_0;
      end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
         off = c - CH_LO_A + 8'd10;
      end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
         off = c - CH_UP_A + 8'd36;
      end
      return off[CODE_W-1:0];
   endfunction

   logic [2:0]              state_ff, state_in;
   logic [RADIX_W-1:0]      len_ff, len_in;
   logic [RADIX_W-1:0]      radix_ff, radix_in;
   logic [VALUE_BITS-1:0]   value_ff, value_in;
   logic [DCNT_W-1:0]       cnt_ff, cnt_in;
   logic [DPTR_W-1:0]       ptr_ff, ptr_in;
   logic [ALNUM_N-1:0]      seen_ff, seen_in;
   logic [ALPHABET_DEPTH-1:0] alpha_valid_ff, alpha_valid_in;
   logic                    rd_valid_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]       rsp_char_ff, rsp_char_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_bad_ff, rsp_bad_in;

   logic                    req_accept;
   logic                    alpha_we;
   logic [AIDX_W-1:0]       alpha_raddr;
   logic [CHAR_W-1:0]       alpha_q;
   logic [CHAR_W-1:0]       alpha_data;
   logic                    dig_we;
   logic [CHAR_W-1:0]       dig_q;
   logic [RADIX_W-1:0]      next_idx;
   logic [CODE_W-1:0]       entry_code;
   logic                    div_start;
   logic [RADIX_W-1:0]      div_divisor;
   div_status_type          div_status;
   logic [VALUE_BITS-1:0]   div_quot;
   logic [RADIX_W-1:0]      div_rem;

   assign req_accept     = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   // alphabet write from a write request inside the table
   assign alpha_we = req_accept && (req_chan.cmd == CMD_WRITE) &&
                     (req_chan.index < IDX_FIELD_W'(ALPHABET_DEPTH));

   // never-written entries read as zero
   assign alpha_data = rd_valid_ff ? alpha_q : '0;
   assign next_idx   = len_ff + 1'b1;
   assign entry_code = alnum_code(alpha_data);

   // alphabet read address by phase
   always_comb begin
      case (state_ff)
         S_CHK: begin
            alpha_raddr = (next_idx < RADIX_W'(ALPHABET_DEPTH)) ?
                          next_idx[AIDX_W-1:0] : '0;
         end
         S_DIV: begin
            alpha_raddr = div_rem[AIDX_W-1:0];
         end
         default: begin
            alpha_raddr = '0;
         end
      endcase
   end

   assign dig_we = (state_ff == S_LOOK);

   // sequencer
   always_comb begin
      state_in       = state_ff;
      len_in         = len_ff;
      radix_in       = radix_ff;
      value_in       = value_ff;
      cnt_in         = cnt_ff;
      ptr_in         = ptr_ff;
      seen_in        = seen_ff;
      alpha_valid_in = alpha_valid_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_char_in    = rsp_char_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_bad_in     = rsp_bad_ff;
      div_start      = 1'b0;
      div_divisor    = radix_ff;

      case (state_ff)
         S_IDLE: begin
            if (alpha_we) begin
               alpha_valid_in[req_chan.index[AIDX_W-1:0]] = 1'b1;
            end
            if (req_accept && (req_chan.cmd == CMD_CONVERT)) begin
               value_in = req_chan.value[VALUE_BITS-1:0];
               len_in   = '0;
               cnt_in   = '0;
               seen_in  = '0;
               state_in = S_CHK;
            end
         end

         // alphabet walk: one entry per cycle, duplicates via seen flags
         S_CHK: begin
            if (alpha_data == '0) begin
               if (len_ff < RADIX_W'(2)) begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = '0;
                  rsp_last_in  = 1'b1;
                  rsp_bad_in   = 1'b1;
                  state_in     = S_OUT_WAIT;
               end else begin
                  radix_in    = len_ff;
                  div_divisor = len_ff;
                  div_start   = 1'b1;
                  state_in    = S_DIV;
               end
            end else if (!is_alnum(alpha_data) || seen_ff[entry_code]) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = '0;
               rsp_last_in  = 1'b1;
               rsp_bad_in   = 1'b1;
               state_in     = S_OUT_WAIT;
            end else begin
               seen_in[entry_code] = 1'b1;
               len_in              = next_idx;
               if (next_idx == RADIX_W'(ALPHABET_DEPTH)) begin
                  radix_in    = next_idx;
                  div_divisor = next_idx;
                  div_start   = 1'b1;
                  state_in    = S_DIV;
               end
            end
         end

         // wait for the divider, then look up the remainder's character
         S_DIV: begin
            if (div_status.done) begin
               value_in = div_quot;
               state_in = S_LOOK;
            end
         end

         // store the character; repeat until the quotient runs out
         S_LOOK: begin
            cnt_in = cnt_ff + 1'b1;
            if (div_status.quot_zero) begin
               ptr_in   = cnt_ff[DPTR_W-1:0];
               state_in = S_OUT_RD;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end

         S_OUT_RD: begin
            state_in = S_OUT_LD;
         end

         S_OUT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = dig_q;
            rsp_last_in  = (ptr_ff == '0);
            rsp_bad_in   = 1'b0;
            state_in     = S_OUT_WAIT;
         end

         S_OUT_WAIT: begin
            if (rsp_chan.ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  ptr_in   = ptr_ff - 1'b1;
                  state_in = S_OUT_RD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         alpha_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         len_ff         <= '0;
         cnt_ff         <= '0;
         ptr_ff         <= '0;
         seen_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         alpha_valid_ff <= alpha_valid_in;
         rd_valid_ff    <= alpha_valid_ff[alpha_raddr];
         rsp_valid_ff   <= rsp_valid_in;
         len_ff         <= len_in;
         cnt_ff         <= cnt_in;
         ptr_ff         <= ptr_in;
         seen_ff        <= seen_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      radix_ff    <= radix_in;
      value_ff    <= value_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   // alphabet table
   rdsc_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (ALPHABET_DEPTH)
   ) u_alpha_ram (
      .clock   (clock),
      .wr_en   (alpha_we),
      .wr_addr (req_chan.index[AIDX_W-1:0]),
      .wr_data (req_chan.char_code),
      .rd_addr (alpha_raddr),
      .rd_data (alpha_q)
   );

   // digit buffer, filled least significant first, read back in reverse
   rdsc_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (VALUE_BITS)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (dig_we),
      .wr_addr (cnt_ff[DPTR_W-1:0]),
      .wr_data (alpha_data),
      .rd_addr (ptr_ff),
      .rd_data (dig_q)
   );

   // shared divider
   rdsc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (value_ff),
      .divisor   (div_divisor),
      .status    (div_status),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.digit_char   = rsp_char_ff;
   assign rsp_chan.last         = rsp_last_ff;
   assign rsp_chan.bad_alphabet = rsp_bad_ff;

endmodule

// ----- src/rdsc_ram.sv -----
// rdsc_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module rdsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/rdsc_divider.sv -----
// rdsc_divider: iterative restoring divider, value by a small radix
// depends on rdsc_pkg; resolves DIV_STEPS quotient bits per cycle
`timescale 1ns / 1ps

module rdsc_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rdsc_pkg::VALUE_BITS-1:0]  dividend,
   input  logic [rdsc_pkg::RADIX_W-1:0]     divisor,
   output rdsc_pkg::div_status_type         status,
   output logic [rdsc_pkg::VALUE_BITS-1:0]  quotient,
   output logic [rdsc_pkg::RADIX_W-1:0]     remainder
);
   import rdsc_pkg::*;

   logic [DIV_W-1:0]   work_ff, work_in;
   logic [RADIX_W-1:0] rem_ff, rem_in;
   logic [RADIX_W-1:0] div_ff, div_in;
   logic [DCYC_W-1:0]  left_ff, left_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   logic [DIV_W-1:0]   step_work;
   logic [RADIX_W-1:0] step_rem;
   logic [RADIX_W:0]   trial;
   logic               ge;

   // DIV_STEPS unrolled steps of shift and conditional subtract
   always_comb begin
      step_rem  = rem_ff;
      step_work = work_ff;
      trial     = '0;
      ge        = 1'b0;
      for (int k = 0; k < DIV_STEPS; k++) begin
         trial = {step_rem, step_work[DIV_W-1]};
         ge    = (trial >= {1'b0, div_ff});
         if (ge) begin
            trial = trial - {1'b0, div_ff};
         end
         step_rem  = trial[RADIX_W-1:0];
         step_work = {step_work[DIV_W-2:0], ge};
      end
   end

   // sequencing of the division
   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      left_in = left_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = DIV_W'(dividend);
         rem_in  = '0;
         div_in  = divisor;
         left_in = DCYC_W'(DIV_CYCLES);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = step_work;
         rem_in  = step_rem;
         left_in = left_ff - 1'b1;
         if (left_ff == DCYC_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         left_ff <= left_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign quotient         = work_ff[VALUE_BITS-1:0];
   assign remainder        = rem_ff;
   assign status.done      = done_ff;
   assign status.quot_zero = (work_ff[VALUE_BITS-1:0] == '0);

endmodule

// ----- src/rdsc_checker.sv -----
// rdsc_checker: port level assertions for the converter, bound to the top level
// depends on rdsc_pkg and radix_digit_string_converter_unit
`timescale 1ns / 1ps

module rdsc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [rdsc_pkg::CHAR_W-1:0] rsp_digit_char,
   input logic                        rsp_last,
   input logic                        rsp_bad_alphabet
);

   // a stalled response stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_digit_char) && $stable(rsp_last) &&
                                  $stable(rsp_bad_alphabet))
      else $error("response payload changed while stalled");

   // an alphabet error is a single flagged response with a zero character
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_alphabet |-> rsp_last && (rsp_digit_char == '0))
      else $error("alphabet error response malformed");

   // no new request taken while a response is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while a response is pending");

   // reset drops any pending response
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind radix_digit_string_converter_unit rdsc_checker u_rdsc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_digit_char   (rsp_chan.digit_char),
   .rsp_last         (rsp_chan.last),
   .rsp_bad_alphabet (rsp_chan.bad_alphabet)
);

// ----- bench/rdsc_stream_checker.sv -----
// rdsc_stream_checker: watches both channels of the converter, predicts the characters
// of each convert request and compares them with the responses; depends on rdsc_pkg,
// rdsc_req_if and rdsc_rsp_if
`timescale 1ns / 1ps

module rdsc_stream_checker (
   input  logic clock,
   input  logic reset,
   rdsc_req_if  req_mon,
   rdsc_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   pending_count
);
   import rdsc_pkg::*;

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last;
      logic              bad_alphabet;
   } char_rsp_type;

   logic [CHAR_W-1:0] alphabet_copy [ALPHABET_DEPTH];
   char_rsp_type      chars_due [$];
   int                errors = 0;

   function automatic logic is_digit_or_letter(logic [CHAR_W-1:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
             (c >= "A" && c <= "Z");
   endfunction

   // base of the current alphabet, zero when it is unusable
   function automatic int unsigned alphabet_base();
      int unsigned len;
      len = 0;
      while (len < ALPHABET_DEPTH && alphabet_copy[len] != '0)
         len++;
      if (len < 2)
         return 0;
      for (int i = 0; i < len; i++) begin
         if (!is_digit_or_letter(alphabet_copy[i]))
            return 0;
         for (int j = i + 1; j < len; j++)
            if (alphabet_copy[i] == alphabet_copy[j])
               return 0;
      end
      return len;
   endfunction

   // characters of one conversion, most significant first
   task automatic queue_conversion(logic [VALUE_BITS-1:0] number);
      int unsigned           base;
      logic [CHAR_W-1:0]     digits [VALUE_BITS];
      int                    count;
      logic [VALUE_BITS-1:0] rest;
      logic [VALUE_BITS-1:0] base_v;
      char_rsp_type          c;
      base = alphabet_base();
      if (base == 0) begin
         c.digit_char   = '0;
         c.last         = 1'b1;
         c.bad_alphabet = 1'b1;
         chars_due.push_back(c);
         return;
      end
      base_v = VALUE_BITS'(base);
      rest   = number;
      count  = 0;
      if (rest == '0) begin
         digits[0] = alphabet_copy[0];
         count     = 1;
      end else begin
         while (rest != '0 && count < VALUE_BITS) begin
            digits[count] = alphabet_copy[int'(rest % base_v)];
            count++;
            rest = rest / base_v;
         end
      end
      for (int k = 0; k < count; k++) begin
         c.digit_char   = digits[count - 1 - k];
         c.last         = (k + 1 == count);
         c.bad_alphabet = 1'b0;
         chars_due.push_back(c);
      end
   endtask

   task automatic check_response();
      char_rsp_type want;
      if (chars_due.size() == 0) begin
         $error("unexpected response digit_char %h last %b bad_alphabet %b",
                rsp_mon.digit_char, rsp_mon.last, rsp_mon.bad_alphabet);
         errors++;
         return;
      end
      want = chars_due.pop_front();
      if (rsp_mon.digit_char !== want.digit_char) begin
         $error("digit_char expected %h actual %h", want.digit_char, rsp_mon.digit_char);
         errors++;
      end
      if (rsp_mon.last !== want.last) begin
         $error("last expected %b actual %b", want.last, rsp_mon.last);
         errors++;
      end
      if (rsp_mon.bad_alphabet !== want.bad_alphabet) begin
         $error("bad_alphabet expected %b actual %b", want.bad_alphabet,
                rsp_mon.bad_alphabet);
         errors++;
      end
   endtask

   // track alphabet writes, queue predictions, compare responses
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ALPHABET_DEPTH; i++)
            alphabet_copy[i] = '0;
         chars_due.delete();
      end else begin
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            if (req_mon.cmd == CMD_WRITE) begin
               if (req_mon.index < ALPHABET_DEPTH)
                  alphabet_copy[req_mon.index] = req_mon.char_code;
            end else begin
               queue_conversion(req_mon.value[VALUE_BITS-1:0]);
            end
         end
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1)
            check_response();
      end
      mismatch_count <= errors;
      pending_count  <= chars_due.size();
   end

endmodule

// ----- bench/tb_radix_digit_string_converter_unit.sv -----
// tb_radix_digit_string_converter_unit: drives alphabet writes and convert requests
// with random idling and gives the verdict; depends on rdsc_pkg, the channel
// interfaces, the converter and rdsc_stream_checker
`timescale 1ns / 1ps

module tb_radix_digit_string_converter_unit;
   import rdsc_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int LONG_HOLD   = 400;
   localparam int PHASE_ITEMS = 35;

   logic clock = 1'b0;
   logic reset;

   int   send_idle_pct;
   int   recv_idle_pct;
   bit   hold_request;
   int   cycle_count = 0;
   int   mismatch_count;
   int   pending_count;
   int   items_sent;

   // stimulus-side image of the loaded digits and the end-marker position
   logic [CHAR_W-1:0] digit_set [ALPHABET_DEPTH];
   int                end_pos;
   int                phase, phase_end, op, pick, new_len, a, b;
   logic [CHAR_W-1:0] tmp, bad_char;

   rdsc_req_if req_chan ();
   rdsc_rsp_if rsp_chan ();

   radix_digit_string_converter_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   rdsc_stream_checker stream_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always #5 clock = ~clock;

   // run-length guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            for (int k = 0; k < LONG_HOLD; k++) begin
               rsp_chan.ready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // offer one request, idling first at random, and wait for the handshake
   task automatic send_request(logic [CMD_W-1:0] cmd, logic [IDX_FIELD_W-1:0] idx,
                               logic [CHAR_W-1:0] ch, logic [VALUE_FIELD_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.cmd       <= cmd;
      req_chan.index     <= idx;
      req_chan.char_code <= ch;
      req_chan.value     <= val;
      do
         @(posedge clock);
      while (req_chan.ready !== 1'b1);
   endtask

   task automatic write_entry(int idx, logic [CHAR_W-1:0] ch);
      send_request(CMD_WRITE, IDX_FIELD_W'(idx), ch, {$urandom, $urandom});
      if (idx < ALPHABET_DEPTH)
         items_sent++;
   endtask

   task automatic convert_value(logic [VALUE_FIELD_W-1:0] val);
      send_request(CMD_CONVERT, IDX_FIELD_W'($urandom_range(63)),
                   CHAR_W'($urandom_range(255)), val);
      items_sent++;
   endtask

   // values spread over zero, all ones, single bits and random widths
   function automatic logic [VALUE_FIELD_W-1:0] pick_value();
      int                       r;
      int                       w;
      logic [VALUE_FIELD_W-1:0] v;
      r = $urandom_range(99);
      v = {$urandom, $urandom};
      if (r < 5)
         v = '0;
      else if (r < 10)
         v = '1;
      else if (r < 20)
         v = 64'd1 << $urandom_range(63);
      else if (r < 60) begin
         w = $urandom_range(1, 63);
         v = v & ((64'd1 << w) - 64'd1);
      end
      return v;
   endfunction

   initial begin
      req_chan.valid     <= 1'b0;
      req_chan.cmd       <= CMD_WRITE;
      req_chan.index     <= '0;
      req_chan.char_code <= '0;
      req_chan.value     <= '0;
      reset              <= 1'b1;
      send_idle_pct = 35;
      recv_idle_pct = 60;
      hold_request  = 1'b0;
      items_sent    = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty, single-character, non-alphanumeric and repeated alphabets
      convert_value(64'd7);
      write_entry(0, "1");
      convert_value('1);
      write_entry(1, "0");
      convert_value('0);
      convert_value('1);
      convert_value(64'h8000_0000_0000_0000);
      write_entry(2, "#");
      convert_value(64'd5);
      write_entry(2, "1");
      convert_value(64'd5);
      write_entry(2, 8'hFF);
      convert_value(64'd5);
      write_entry(2, "z");
      convert_value('1);
      // writes past the table are dropped
      write_entry(63, "A");
      write_entry(62, "B");
      convert_value(64'd12345);
      // end marker at the front hides the kept entries behind it
      write_entry(0, 8'h00);
      convert_value(64'd9);
      write_entry(0, "Q");
      convert_value(64'd1);

      // load a shuffled full alphabet of all 62 digits and letters
      for (int i = 0; i < ALPHABET_DEPTH; i++)
         digit_set[i] = (i < 10) ? CHAR_W'(8'h30 + i) :
                        (i < 36) ? CHAR_W'(8'h61 + i - 10) : CHAR_W'(8'h41 + i - 36);
      for (int i = ALPHABET_DEPTH - 1; i > 0; i--) begin
         a            = $urandom_range(i);
         tmp          = digit_set[i];
         digit_set[i] = digit_set[a];
         digit_set[a] = tmp;
      end
      for (int i = 0; i < ALPHABET_DEPTH; i++)
         write_entry(i, digit_set[i]);
      end_pos = ALPHABET_DEPTH;
      convert_value('1);
      convert_value(pick_value());

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 35; recv_idle_pct = 60; end
            1: begin send_idle_pct = 60; recv_idle_pct = 35; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         // long receiver hold-off while requests keep coming
         if (phase == 2) begin
            hold_request = 1'b1;
            convert_value('1);
         end
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            op = $urandom_range(99);
            if (op < 45) begin
               convert_value(pick_value());
            end else if (op < 60) begin
               // move the end marker to change the base
               pick = $urandom_range(99);
               if (pick < 5)
                  new_len = $urandom_range(1);
               else if (pick < 70)
                  new_len = $urandom_range(2, 16);
               else if (pick < 85)
                  new_len = $urandom_range(17, ALPHABET_DEPTH - 1);
               else
                  new_len = ALPHABET_DEPTH;
               if (new_len != end_pos) begin
                  if (end_pos < ALPHABET_DEPTH)
                     write_entry(end_pos, digit_set[end_pos]);
                  if (new_len < ALPHABET_DEPTH)
                     write_entry(new_len, 8'h00);
                  end_pos = new_len;
               end
               convert_value(pick_value());
            end else if (op < 72) begin
               // swap two digits, keeping the alphabet valid
               a            = $urandom_range(ALPHABET_DEPTH - 1);
               b            = $urandom_range(ALPHABET_DEPTH - 1);
               tmp          = digit_set[a];
               digit_set[a] = digit_set[b];
               digit_set[b] = tmp;
               if (a != end_pos)
                  write_entry(a, digit_set[a]);
               if (b != end_pos && b != a)
                  write_entry(b, digit_set[b]);
            end else if (op < 84) begin
               // spoil one active entry, convert, then repair it
               if (end_pos >= 2) begin
                  a        = $urandom_range(end_pos - 1);
                  b        = $urandom_range(end_pos - 1);
                  bad_char = $urandom_range(1) ? CHAR_W'($urandom_range(255)) : digit_set[b];
                  write_entry(a, bad_char);
                  convert_value(pick_value());
                  write_entry(a, digit_set[a]);
               end else begin
                  convert_value(pick_value());
               end
            end else if (op < 90) begin
               write_entry($urandom_range(ALPHABET_DEPTH, 63), CHAR_W'($urandom_range(255)));
            end else begin
               convert_value($urandom_range(1) ? '1 : '0);
            end
         end
      end
      req_chan.valid <= 1'b0;

      // drain, then a quiet tail to catch stray responses
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- sim.f -----
src/rdsc_pkg.sv
src/rdsc_req_if.sv
src/rdsc_rsp_if.sv
src/rdsc_ram.sv
src/rdsc_divider.sv
src/radix_digit_string_converter_unit.sv
src/rdsc_checker.sv
bench/rdsc_stream_checker.sv
bench/tb_radix_digit_string_converter_unit.sv
